### rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: sizes, request
// and status codes, sequencer states and the memory access bundle.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned POS_W     = 9;
  localparam int unsigned MODE_W    = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]           addr_t;
  typedef logic [CNT_W-1:0]            cnt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_INSERT_AT  = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_REMOVE_AT  = 3'd5,
    MODE_READ       = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_BAD_POS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAPTURE,
    S_SHIFT,
    S_PLACE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

endpackage

### rtl/ple_if.sv
// ----------------------------------------------------------------------------
// ple_if
// Valid/ready channels of the positional list engine: request and response.
// ----------------------------------------------------------------------------
interface ple_req_if
  import ple_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [WORD_BITS-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

interface ple_rsp_if
  import ple_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic signed [WORD_BITS-1:0] word_out;
  logic [CNT_W-1:0]            entry_count;

  modport source (output valid, status, word_out, entry_count, input ready);
  modport sink   (input valid, status, word_out, entry_count, output ready);
endinterface

### rtl/ple_store.sv
// ----------------------------------------------------------------------------
// ple_store
// List storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_store
  import ple_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t mem_req_i,
  output word_t    rdata_o
);

  word_t mem_q [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Request decode and move sequencer: opens or closes a gap in the packed
// store by moving one word per cycle, or reads a word, then responds; a failed request responds directly.
// ----------------------------------------------------------------------------
module ple_ctrl
  import ple_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  ple_req_if.sink        req_i,
  ple_rsp_if.source      rsp_o,
  output mem_req_t       mem_req_o,
  input  word_t          rdata_i
);

  state_e  state_q, state_d;
  cnt_t    len_q, len_d;
  addr_t   idx_q, idx_d;
  addr_t   src_q, src_d;
  addr_t   wr_q, wr_d;
  cnt_t    moves_q, moves_d;
  logic    pend_q, pend_d;
  logic    down_q, down_d;
  op_e     op_q, op_d;
  word_t   value_q, value_d;
  word_t   word_q, word_d;
  status_e status_q, status_d;

  cnt_t    n;
  cnt_t    pos;
  cnt_t    pos_m1;
  status_e dec_status;
  op_e     dec_op;
  cnt_t    dec_idx;
  logic    accept;

  assign n      = len_q;
  assign pos    = cnt_t'(req_i.position);
  assign pos_m1 = pos - cnt_t'(1);
  assign accept = req_i.valid && req_i.ready;

  // Decode the request against the current length
  always_comb begin
    dec_status = STATUS_OK;
    dec_op     = OP_NONE;
    dec_idx    = '0;
    unique case (mode_e'(req_i.mode))
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT_AT: begin
        if (n == cnt_t'(DEPTH)) begin
          dec_status = STATUS_FULL;
        end else begin
          dec_op = OP_INSERT;
          priority if (req_i.mode == MODE_PUSH_FRONT || n == '0) begin
            dec_idx = '0;
          end else if (req_i.mode == MODE_PUSH_BACK) begin
            dec_idx = n;
          end else if (pos == cnt_t'(1)) begin
            dec_idx = '0;
          end else if (pos == n) begin
            dec_idx = n;
          end else if (pos > cnt_t'(1) && pos < n) begin
            dec_idx = pos_m1;
          end else begin
            dec_status = STATUS_BAD_POS;
            dec_op     = OP_NONE;
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE_AT: begin
        if (n == '0) begin
          dec_status = STATUS_EMPTY;
        end else begin
          dec_op = OP_REMOVE;
          priority if (req_i.mode == MODE_POP_FRONT || n == cnt_t'(1)) begin
            dec_idx = '0;
          end else if (req_i.mode == MODE_POP_BACK) begin
            dec_idx = n - cnt_t'(1);
          end else if (pos >= cnt_t'(1) && pos <= n) begin
            dec_idx = pos_m1;
          end else begin
            dec_status = STATUS_BAD_POS;
            dec_op     = OP_NONE;
          end
        end
      end
      MODE_READ: begin
        if (n == '0) begin
          dec_status = STATUS_EMPTY;
        end else if (pos >= cnt_t'(1) && pos <= n) begin
          dec_op  = OP_READ;
          dec_idx = pos_m1;
        end else begin
          dec_status = STATUS_BAD_POS;
        end
      end
      default: begin
        dec_status = STATUS_BAD_POS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      moves_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      moves_q <= moves_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    src_q    <= src_d;
    wr_q     <= wr_d;
    down_q   <= down_d;
    op_q     <= op_d;
    value_q  <= value_d;
    word_q   <= word_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    idx_d     = idx_q;
    src_d     = src_q;
    wr_d      = wr_q;
    moves_d   = moves_q;
    pend_d    = pend_q;
    down_d    = down_q;
    op_d      = op_q;
    value_d   = value_q;
    word_d    = word_q;
    status_d  = status_q;
    mem_req_o = '{we: 1'b0, waddr: wr_q, wdata: rdata_i, raddr: src_q};

    unique case (state_q)
      S_IDLE: begin
        // The read of the target entry goes out now; data is back next cycle
        mem_req_o.raddr = dec_idx[ADDR_W-1:0];
        if (accept) begin
          op_d     = dec_op;
          idx_d    = dec_idx[ADDR_W-1:0];
          value_d  = req_i.value;
          status_d = dec_status;
          word_d   = '0;
          pend_d   = 1'b0;
          unique case (dec_op)
            OP_INSERT: begin
              down_d  = 1'b1;
              src_d   = addr_t'(n - cnt_t'(1));
              moves_d = n - dec_idx;
              state_d = S_SHIFT;
            end
            OP_REMOVE, OP_READ: begin
              state_d = S_CAPTURE;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_CAPTURE: begin
        word_d = rdata_i;
        if (op_q == OP_READ) begin
          state_d = S_RESP;
        end else begin
          down_d  = 1'b0;
          src_d   = idx_q + addr_t'(1);
          moves_d = len_q - cnt_t'(idx_q) - cnt_t'(1);
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // Write back the word read last cycle, one slot over
        if (pend_q) begin
          mem_req_o.we = 1'b1;
        end
        if (moves_q != '0) begin
          pend_d  = 1'b1;
          wr_d    = down_q ? src_q + addr_t'(1) : src_q - addr_t'(1);
          src_d   = down_q ? src_q - addr_t'(1) : src_q + addr_t'(1);
          moves_d = moves_q - cnt_t'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (op_q == OP_INSERT) begin
              state_d = S_PLACE;
            end else begin
              len_d   = len_q - cnt_t'(1);
              state_d = S_RESP;
            end
          end
        end
      end
      S_PLACE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = value_q;
        len_d           = len_q + cnt_t'(1);
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = (state_q == S_RESP);
  assign rsp_o.status      = status_q;
  assign rsp_o.word_out    = word_q;
  assign rsp_o.entry_count = len_q;

endmodule

### rtl/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of up to DEPTH words with front, back and positional insert,
// removal and read; one response per request.
//
//   channel  dir  fields                          transfer
//   req_i    in   mode, value, position           valid && ready
//   rsp_o    out  status, word_out, entry_count   valid && ready
//
// One request at a time: ready is low from the accepted transfer until its
// response is taken. Errors go straight to the response and reads pass through
// the capture state; an insert shifts the words from its index on up one slot
// and then places the new word, a removal captures the word and closes the gap,
// the single store write port moving one word per cycle. A stalled response
// holds the block. Reset clears the count and the sequencer state, not the store.
// ----------------------------------------------------------------------------
module positional_list_engine_top
  import ple_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ple_req_if.sink   req_i,
  ple_rsp_if.source rsp_o
);

  mem_req_t mem_req;
  word_t    rdata;

  ple_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .rdata_i   (rdata)
  );

  ple_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

endmodule

### rtl/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker
  import ple_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [1:0]       status_i,
  input logic [WORD_BITS-1:0] word_out_i,
  input logic [CNT_W-1:0] entry_count_i
);

  // Hold a stalled response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(status_i) && $stable(word_out_i) && $stable(entry_count_i))
    else $error("response changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request taken while a response is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready after a transfer without a response");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != STATUS_OK |-> word_out_i == '0)
    else $error("nonzero word on a failed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> entry_count_i <= CNT_W'(DEPTH))
    else $error("count beyond capacity");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .word_out_i    (rsp_o.word_out),
  .entry_count_i (rsp_o.entry_count)
);

### sim/positional_list_engine_top_tb.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top_tb
// Self-checking bench for the positional list engine. A directed table of
// corner requests runs first, then about 900 random requests, including a
// fill to full and a drain to empty. Each response is checked field by field
// against the table's typed response or a prediction by an in-bench list
// model. Requests get random gaps and responses random stalls.
// ----------------------------------------------------------------------------
module positional_list_engine_top_tb;
  import ple_pkg::*;

  typedef logic [MODE_W-1:0] mode_bits_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef struct packed {
    status_e status;
    word_t   word;
    cnt_t    count;
  } list_rsp_t;

  typedef struct packed {
    mode_bits_t mode;
    word_t      value;
    pos_t       pos;
    logic       typed;
    list_rsp_t  rsp;
  } dir_row_t;

  localparam mode_bits_t MODE_UNUSED   = 3'd7;
  localparam int         RANDOM_ITEMS  = 900;
  localparam int         REPORT_LIMIT  = 10;
  localparam int         RUN_LIMIT     = 15_000_000;

  localparam word_t W_MIN = word_t'(32'h8000_0000);
  localparam word_t W_MAX = word_t'(32'h7fff_ffff);
  localparam word_t W_ONES = word_t'(32'hffff_ffff);
  localparam word_t EXTREMES [4] = '{W_MIN, W_MAX, word_t'(0), W_ONES};

  // Typed responses only where they follow at a glance; the rest use the model.
  localparam dir_row_t DIR_ROWS [25] = '{
    '{MODE_POP_FRONT,  '0,           9'd0,   1'b1, '{STATUS_EMPTY,   '0, 9'd0}},
    '{MODE_POP_BACK,   '0,           9'd0,   1'b1, '{STATUS_EMPTY,   '0, 9'd0}},
    '{MODE_REMOVE_AT,  '0,           9'd1,   1'b1, '{STATUS_EMPTY,   '0, 9'd0}},
    '{MODE_READ,       '0,           9'd1,   1'b1, '{STATUS_EMPTY,   '0, 9'd0}},
    '{MODE_INSERT_AT,  W_MIN,        9'd300, 1'b1, '{STATUS_OK,      '0, 9'd1}},
    '{MODE_UNUSED,     W_ONES,       9'd511, 1'b1, '{STATUS_BAD_POS, '0, 9'd1}},
    '{MODE_PUSH_FRONT, W_MAX,        9'd0,   1'b1, '{STATUS_OK,      '0, 9'd2}},
    '{MODE_PUSH_BACK,  W_ONES,       9'd511, 1'b1, '{STATUS_OK,      '0, 9'd3}},
    '{MODE_INSERT_AT,  word_t'(5),   9'd1,   1'b1, '{STATUS_OK,      '0, 9'd4}},
    '{MODE_INSERT_AT,  word_t'(6),   9'd4,   1'b1, '{STATUS_OK,      '0, 9'd5}},
    '{MODE_INSERT_AT,  word_t'(7),   9'd3,   1'b1, '{STATUS_OK,      '0, 9'd6}},
    '{MODE_INSERT_AT,  word_t'(8),   9'd0,   1'b1, '{STATUS_BAD_POS, '0, 9'd6}},
    '{MODE_INSERT_AT,  word_t'(9),   9'd7,   1'b1, '{STATUS_BAD_POS, '0, 9'd6}},
    '{MODE_READ,       '0,           9'd0,   1'b1, '{STATUS_BAD_POS, '0, 9'd6}},
    '{MODE_READ,       '0,           9'd511, 1'b1, '{STATUS_BAD_POS, '0, 9'd6}},
    '{MODE_READ,       '0,           9'd1,   1'b0, '0},
    '{MODE_READ,       '0,           9'd6,   1'b0, '0},
    '{MODE_REMOVE_AT,  '0,           9'd0,   1'b1, '{STATUS_BAD_POS, '0, 9'd6}},
    '{MODE_REMOVE_AT,  '0,           9'd7,   1'b1, '{STATUS_BAD_POS, '0, 9'd6}},
    '{MODE_REMOVE_AT,  '0,           9'd3,   1'b0, '0},
    '{MODE_POP_FRONT,  '0,           9'd0,   1'b0, '0},
    '{MODE_POP_BACK,   '0,           9'd0,   1'b0, '0},
    '{MODE_POP_BACK,   '0,           9'd0,   1'b0, '0},
    '{MODE_POP_FRONT,  '0,           9'd0,   1'b0, '0},
    '{MODE_REMOVE_AT,  '0,           9'd400, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  ple_req_if req_if ();
  ple_rsp_if rsp_if ();

  positional_list_engine_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  word_t     list_words [$];
  list_rsp_t pending_rsp [$];

  int  sent, checked, mismatches, rand_items;
  int  peak_count, n_full, n_empty, n_bad_pos;
  bit  req_idle_on = 1'b1;
  bit  rsp_idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #RUN_LIMIT;
    $display("end of test: mismatches");
    $finish;
  end

  // Apply one request to the list copy and return the response it produces.
  function automatic list_rsp_t list_apply(mode_bits_t mode, word_t value, pos_t pos);
    list_rsp_t rsp;
    int unsigned n;
    n = list_words.size();
    rsp = '{STATUS_OK, '0, '0};
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT_AT: begin
        if (n >= DEPTH) rsp.status = STATUS_FULL;
        else if (mode == MODE_PUSH_FRONT || n == 0) list_words.push_front(value);
        else if (mode == MODE_PUSH_BACK) list_words.push_back(value);
        else if (pos == 1) list_words.push_front(value);
        else if (pos == n) list_words.push_back(value);
        else if (pos > 1 && pos < n) list_words.insert(pos - 1, value);
        else rsp.status = STATUS_BAD_POS;
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE_AT: begin
        if (n == 0) rsp.status = STATUS_EMPTY;
        else if (mode == MODE_POP_FRONT || n == 1) rsp.word = list_words.pop_front();
        else if (mode == MODE_POP_BACK) rsp.word = list_words.pop_back();
        else if (pos >= 1 && pos <= n) begin
          rsp.word = list_words[pos - 1];
          list_words.delete(pos - 1);
        end else rsp.status = STATUS_BAD_POS;
      end
      MODE_READ: begin
        if (n == 0) rsp.status = STATUS_EMPTY;
        else if (pos >= 1 && pos <= n) rsp.word = list_words[pos - 1];
        else rsp.status = STATUS_BAD_POS;
      end
      default: rsp.status = STATUS_BAD_POS;
    endcase
    rsp.count = cnt_t'(list_words.size());
    if (list_words.size() > peak_count) peak_count = list_words.size();
    case (rsp.status)
      STATUS_FULL:    n_full++;
      STATUS_EMPTY:   n_empty++;
      STATUS_BAD_POS: n_bad_pos++;
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic send_req(input mode_bits_t mode, input word_t value, input pos_t pos,
                          input logic typed, input list_rsp_t typed_rsp);
    int        gap;
    list_rsp_t model_rsp;
    if ($urandom_range(0, 39) == 0) req_idle_on = !req_idle_on;
    gap = req_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= mode;
    req_if.value    <= value;
    req_if.position <= pos;
    do @(posedge clk_i); while (!req_if.ready);
    model_rsp = list_apply(mode, value, pos);
    pending_rsp.push_back(typed ? typed_rsp : model_rsp);
    sent++;
  endtask

  // grow sets the share of inserts among list-changing requests, in percent.
  task automatic send_random(input int grow);
    int unsigned r, n;
    mode_bits_t  mode;
    word_t       value;
    pos_t        pos;
    n = list_words.size();
    r = $urandom_range(0, 99);
    if (r < 3) mode = MODE_UNUSED;
    else if (r < 15) mode = MODE_READ;
    else if (r < 15 + grow * 85 / 100)
      mode = mode_bits_t'($urandom_range(MODE_PUSH_FRONT, MODE_INSERT_AT));
    else
      mode = mode_bits_t'($urandom_range(MODE_POP_FRONT, MODE_REMOVE_AT));
    value = ($urandom_range(0, 4) == 0) ? EXTREMES[$urandom_range(0, 3)] : word_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60) pos = pos_t'($urandom_range(1, n > 0 ? n : 1));
    else if (r < 75) pos = pos_t'(n);
    else if (r < 85) pos = pos_t'(n + 1);
    else pos = pos_t'($urandom_range(0, 511));
    send_req(mode, value, pos, 1'b0, '0);
    rand_items++;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.mode     <= MODE_PUSH_FRONT;
    req_if.value    <= '0;
    req_if.position <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i])
      send_req(DIR_ROWS[i].mode, DIR_ROWS[i].value, DIR_ROWS[i].pos,
               DIR_ROWS[i].typed, DIR_ROWS[i].rsp);

    repeat (150) send_random(50);
    while (list_words.size() < DEPTH) send_random(100);
    repeat (12) send_random(100);
    while (list_words.size() > 0) send_random(0);
    repeat (12) send_random(0);
    while (rand_items < RANDOM_ITEMS) send_random(55);

    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("%0d requests sent, %0d responses checked, peak list length %0d",
             sent, checked, peak_count);
    $display("full answers %0d, empty answers %0d, bad position answers %0d",
             n_full, n_empty, n_bad_pos);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int        stall;
    list_rsp_t want, got;
    rsp_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rsp_idle_on = !rsp_idle_on;
      stall = rsp_idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      got.status = status_e'(rsp_if.status);
      got.word   = rsp_if.word_out;
      got.count  = rsp_if.entry_count;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: response with nothing pending: status %0d word %h count %0d",
                   $realtime, got.status, got.word, got.count);
      end else begin
        want = pending_rsp.pop_front();
        checked++;
        if (got.status !== want.status || got.word !== want.word ||
            got.count !== want.count) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: response %0d: want %0d/%h/%0d, got %0d/%h/%0d",
                     $realtime, checked, want.status, want.word, want.count,
                     got.status, got.word, got.count);
        end
      end
    end
  end

endmodule
